>>> rtl/core/pcc_pkg.sv
// Shared types and constants of the pileup column consensus core.
// Depends on nothing; every other file of the core but pcc_fifo imports it.
package pcc_pkg;

  localparam int NUM_CLASSES = 6;
  localparam int CLS_W       = 3;
  localparam int QUAL_W      = 8;
  localparam int QUAL_CAP    = 93;
  localparam int QTAB_N      = QUAL_CAP + 1;
  localparam int QIDX_W      = 7;
  localparam int SUM_W       = 32;
  localparam int CNT_W       = 16;
  localparam int MEAN_W      = 16;

  // round(10^(-k/10) * 2^32) for k = 0..9, 33 bits so that k = 0 fits.
  localparam logic [32:0] FRAC_POW_TAB [10] = '{
    33'd4294967296, 33'd3411613790, 33'd2709941160, 33'd2152582777,
    33'd1709857278, 33'd1358187913, 33'd1078847007, 33'd856958639,
    33'd680706443,  33'd540704347
  };

endpackage

>>> rtl/core/pcc_front.sv
// Front end: registers each observation and looks up its class weights.
// Depends on pcc_pkg for the quality table and field widths.
module pcc_front import pcc_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int WW = FRAC_BITS + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [CLS_W-1:0] in_base_class,
  input  logic [QUAL_W-1:0] in_quality,
  input  logic             in_column_end,
  output logic             q_valid,
  input  logic             q_ready,
  output logic [CLS_W-1:0] q_cls,
  output logic [WW-1:0]    q_p,
  output logic [WW-1:0]    q_other,
  output logic             q_last
);

  // Error weight e for quality q, rounded and never zero.
  function automatic logic [WW-1:0] err_weight(int q);
    logic [32:0] r;
    logic [32:0] e;
    r = FRAC_POW_TAB[q % 10];
    for (int i = 0; i < q / 10; i++) begin
      r = r / 33'd10;
    end
    e = (r + (33'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    if (e == 33'd0) begin
      e = 33'd1;
    end
    return WW'(e);
  endfunction

  logic [WW-1:0] p_rom [QTAB_N];
  logic [WW-1:0] o_rom [QTAB_N];

  for (genvar g = 0; g < QTAB_N; g++) begin : g_rom
    localparam logic [WW-1:0] EW = err_weight(g);
    assign p_rom[g] = (WW'(1) << FRAC_BITS) - EW;
    assign o_rom[g] = EW / WW'(5);
  end

  logic              valid_r;
  logic [CLS_W-1:0]  cls_r;
  logic [WW-1:0]     p_r;
  logic [WW-1:0]     other_r;
  logic              last_r;
  logic [QIDX_W-1:0] qidx;
  logic              take;

  assign qidx     = (in_quality > QUAL_W'(QUAL_CAP)) ? QIDX_W'(QUAL_CAP)
                                                      : in_quality[QIDX_W-1:0];
  assign in_ready = !valid_r || q_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cls_r   <= in_base_class;
      p_r     <= p_rom[qidx];
      other_r <= o_rom[qidx];
      last_r  <= in_column_end;
    end
  end

  assign q_valid = valid_r;
  assign q_cls   = cls_r;
  assign q_p     = p_r;
  assign q_other = other_r;
  assign q_last  = last_r;

endmodule

>>> rtl/core/pcc_fifo.sv
// Short first-in first-out queue that decouples the front and back ends.
// Depends on nothing beyond its parameters.
module pcc_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [DW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wptr_r;
  logic [AW-1:0] rptr_r;
  logic [AW:0]   cnt_r;
  logic          push;
  logic          pop;

  assign wr_ready = (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

>>> rtl/core/pcc_div.sv
// Restoring divider, one quotient bit per cycle, for the mean weight.
// Depends on pcc_pkg for the sum and count widths.
module pcc_div import pcc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W);

  logic              run_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_sub;
  logic              qbit;

  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign qbit    = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= STEP_W'(SUM_W - 1);
      end else if (run_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[SUM_W-2:0], qbit};
      rem_r <= qbit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/core/pcc_back.sv
// Back end: accumulates class sums and counts, and on column end scans for
// the maximum and emits each tied class. Depends on pcc_pkg and pcc_div.
module pcc_back import pcc_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_DEPTH = 65535,
  localparam int WW = FRAC_BITS + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  logic [CLS_W-1:0]  q_cls,
  input  logic [WW-1:0]     q_p,
  input  logic [WW-1:0]     q_other,
  input  logic              q_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CLS_W-1:0]  out_winner_class,
  output logic [SUM_W-1:0]  out_weight_sum,
  output logic [MEAN_W-1:0] out_mean_weight,
  output logic [CNT_W-1:0]  out_class_count,
  output logic              out_final_winner
);

  localparam logic [CNT_W-1:0] DEPTH_LIM =
    (MAX_DEPTH > 65535) ? {CNT_W{1'b1}} : CNT_W'(MAX_DEPTH);
  localparam logic [CLS_W-1:0] IDX_LAST = CLS_W'(NUM_CLASSES - 1);

  typedef enum logic [4:0] {
    ST_ACC  = 5'b00001,
    ST_MAX  = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [SUM_W-1:0]  sum_r [NUM_CLASSES];
  logic [SUM_W-1:0]  sum_nxt [NUM_CLASSES];
  logic [CNT_W-1:0]  cnt_r [NUM_CLASSES];
  logic [CNT_W-1:0]  cnt_nxt [NUM_CLASSES];
  logic [CNT_W-1:0]  depth_r, depth_nxt;
  logic [CLS_W-1:0]  idx_r, idx_nxt;
  logic [CLS_W-1:0]  lastidx_r, lastidx_nxt;
  logic [SUM_W-1:0]  maxv_r, maxv_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [CLS_W-1:0]  ocls_r;
  logic [SUM_W-1:0]  osum_r;
  logic [MEAN_W-1:0] omean_r;
  logic [CNT_W-1:0]  ocnt_r;
  logic              ofinal_r;
  logic              load_out;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;
  logic              pop;
  logic [SUM_W:0]    add_w [NUM_CLASSES];

  pcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[idx_r]),
    .divisor  (depth_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign q_ready = (state_r == ST_ACC);
  assign pop     = q_valid && q_ready;

  for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_add
    assign add_w[g] = {1'b0, sum_r[g]}
                    + (SUM_W+1)'((q_cls == CLS_W'(g)) ? q_p : q_other);
  end

  always_comb begin
    state_nxt   = state_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    depth_nxt   = depth_r;
    idx_nxt     = idx_r;
    lastidx_nxt = lastidx_r;
    maxv_nxt    = maxv_r;
    ovalid_nxt  = ovalid_r;
    load_out    = 1'b0;
    div_start   = 1'b0;
    case (state_r)
      ST_ACC: begin
        if (pop) begin
          if ((q_cls <= IDX_LAST) && (depth_r < DEPTH_LIM)) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
              sum_nxt[i] = add_w[i][SUM_W] ? {SUM_W{1'b1}} : add_w[i][SUM_W-1:0];
            end
            if (cnt_r[q_cls] != {CNT_W{1'b1}}) begin
              cnt_nxt[q_cls] = cnt_r[q_cls] + CNT_W'(1);
            end
            depth_nxt = depth_r + CNT_W'(1);
          end
          if (q_last) begin
            state_nxt   = ST_MAX;
            idx_nxt     = '0;
            maxv_nxt    = '0;
            lastidx_nxt = '0;
          end
        end
      end
      ST_MAX: begin
        if (sum_r[idx_r] > maxv_r) begin
          maxv_nxt    = sum_r[idx_r];
          lastidx_nxt = idx_r;
        end else if (sum_r[idx_r] == maxv_r) begin
          lastidx_nxt = idx_r;
        end
        if (idx_r == IDX_LAST) begin
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end else begin
          idx_nxt = idx_r + CLS_W'(1);
        end
      end
      ST_SCAN: begin
        if (sum_r[idx_r] == maxv_r) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          idx_nxt = idx_r + CLS_W'(1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          load_out   = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (ovalid_r && out_ready) begin
          ovalid_nxt = 1'b0;
          if (ofinal_r) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
              sum_nxt[i] = '0;
              cnt_nxt[i] = '0;
            end
            depth_nxt = '0;
            state_nxt = ST_ACC;
          end else begin
            idx_nxt   = idx_r + CLS_W'(1);
            state_nxt = ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_ACC;
      ovalid_r  <= 1'b0;
      depth_r   <= '0;
      idx_r     <= '0;
      lastidx_r <= '0;
      maxv_r    <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        sum_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      ovalid_r  <= ovalid_nxt;
      depth_r   <= depth_nxt;
      idx_r     <= idx_nxt;
      lastidx_r <= lastidx_nxt;
      maxv_r    <= maxv_nxt;
      sum_r     <= sum_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ocls_r   <= idx_r;
      osum_r   <= sum_r[idx_r];
      ocnt_r   <= cnt_r[idx_r];
      ofinal_r <= (idx_r == lastidx_r);
      if (depth_r == '0) begin
        omean_r <= '0;
      end else if (|div_quo[SUM_W-1:MEAN_W]) begin
        omean_r <= {MEAN_W{1'b1}};
      end else begin
        omean_r <= div_quo[MEAN_W-1:0];
      end
    end
  end

  assign out_valid        = ovalid_r;
  assign out_winner_class = ocls_r;
  assign out_weight_sum   = osum_r;
  assign out_mean_weight  = omean_r;
  assign out_class_count  = ocnt_r;
  assign out_final_winner = ofinal_r;

endmodule

>>> rtl/core/pileup_column_consensus_core.sv
// Top level of the pileup column consensus core.
// Depends on pcc_pkg, pcc_front, pcc_fifo and pcc_back.
//
// Each word on the input channel is one observation of a reference column.
// The front end takes one word per cycle and the back end folds one
// observation per cycle into the six class sums, so a column streams at one
// observation per cycle as long as no column end is being finished; a
// four-entry queue between the two ends absorbs short back-end stalls. On a
// column's last observation the back end steps through the six sums to find
// the maximum, then for each tied class scans on to that class, runs the
// shared bit-serial divider that forms the mean weight, and holds the result
// word until it is taken; the queue and the front-end register keep accepting
// observations of the next column meanwhile, up to five words.
module pileup_column_consensus_core import pcc_pkg::*; #(
  parameter int MAX_DEPTH        = 65535,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CLS_W-1:0]  in_base_class,
  input  logic [QUAL_W-1:0] in_quality,
  input  logic              in_column_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CLS_W-1:0]  out_winner_class,
  output logic [SUM_W-1:0]  out_weight_sum,
  output logic [MEAN_W-1:0] out_mean_weight,
  output logic [CNT_W-1:0]  out_class_count,
  output logic              out_final_winner
);

  localparam int WW      = WEIGHT_FRAC_BITS + 1;
  localparam int QDW     = CLS_W + 2 * WW + 1;
  localparam int Q_DEPTH = 4;

  logic             f_valid;
  logic             f_ready;
  logic [CLS_W-1:0] f_cls;
  logic [WW-1:0]    f_p;
  logic [WW-1:0]    f_other;
  logic             f_last;
  logic             b_valid;
  logic             b_ready;
  logic [QDW-1:0]   b_data;

  pcc_front #(
    .FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_base_class (in_base_class),
    .in_quality    (in_quality),
    .in_column_end (in_column_end),
    .q_valid       (f_valid),
    .q_ready       (f_ready),
    .q_cls         (f_cls),
    .q_p           (f_p),
    .q_other       (f_other),
    .q_last        (f_last)
  );

  pcc_fifo #(
    .DW    (QDW),
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_cls, f_p, f_other, f_last}),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  pcc_back #(
    .FRAC_BITS (WEIGHT_FRAC_BITS),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (b_valid),
    .q_ready          (b_ready),
    .q_cls            (b_data[QDW-1 -: CLS_W]),
    .q_p              (b_data[2*WW : WW+1]),
    .q_other          (b_data[WW:1]),
    .q_last           (b_data[0]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_winner_class (out_winner_class),
    .out_weight_sum   (out_weight_sum),
    .out_mean_weight  (out_mean_weight),
    .out_class_count  (out_class_count),
    .out_final_winner (out_final_winner)
  );

endmodule

>>> tb/pcc_vote_checker.sv
// Checker for the pileup column consensus core: predicts the tied winners of each column.
// It watches both channels, compares every result word field by field and counts failures.
// Depends on pcc_pkg for the port widths and the class count.
module pcc_vote_checker import pcc_pkg::*; #(
  parameter int MAX_DEPTH        = 65535,
  parameter int WEIGHT_FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CLS_W-1:0]  in_base_class,
  input  logic [QUAL_W-1:0] in_quality,
  input  logic              in_column_end,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [CLS_W-1:0]  out_winner_class,
  input  logic [SUM_W-1:0]  out_weight_sum,
  input  logic [MEAN_W-1:0] out_mean_weight,
  input  logic [CNT_W-1:0]  out_class_count,
  input  logic              out_final_winner,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [SUM_W-1:0]  sum;
    logic [MEAN_W-1:0] mean;
    logic [CNT_W-1:0]  cnt;
    logic              last;
  } vote_t;

  // The value 10^(-k/10) scaled by 2^32 and rounded, for k = 0..9.
  localparam longint unsigned TENTH_DECADE_TAB [10] = '{
    64'd4294967296, 64'd3411613790, 64'd2709941160, 64'd2152582777,
    64'd1709857278, 64'd1358187913, 64'd1078847007, 64'd856958639,
    64'd680706443,  64'd540704347
  };
  localparam int DEPTH_CAP = (MAX_DEPTH > 65535) ? 65535 : MAX_DEPTH;

  logic [SUM_W-1:0] class_sum [NUM_CLASSES];
  logic [CNT_W-1:0] class_obs [NUM_CLASSES];
  logic [CNT_W-1:0] col_depth;
  vote_t            winners_due [$];
  int               fails = 0;

  always @(posedge clk) begin : track
    longint unsigned div, err, inc, acc, mean;
    logic [SUM_W-1:0] peak;
    int qc, last_tie;
    vote_t want, v;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        class_sum[c] = '0;
        class_obs[c] = '0;
      end
      col_depth = '0;
      winners_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (winners_due.size() == 0) begin
          $error("unexpected result word: winner_class %0d, weight_sum %0d",
                 out_winner_class, out_weight_sum);
          fails++;
        end else begin
          want = winners_due[0];
          winners_due.delete(0);
          if (out_winner_class !== want.cls) begin
            $error("winner_class: expected %0d, actual %0d", want.cls, out_winner_class);
            fails++;
          end
          if (out_weight_sum !== want.sum) begin
            $error("weight_sum: expected %0d, actual %0d", want.sum, out_weight_sum);
            fails++;
          end
          if (out_mean_weight !== want.mean) begin
            $error("mean_weight: expected %0d, actual %0d", want.mean, out_mean_weight);
            fails++;
          end
          if (out_class_count !== want.cnt) begin
            $error("class_count: expected %0d, actual %0d", want.cnt, out_class_count);
            fails++;
          end
          if (out_final_winner !== want.last) begin
            $error("final_winner: expected %0d, actual %0d", want.last, out_final_winner);
            fails++;
          end
        end
      end

      if (in_valid && in_ready) begin
        if (in_base_class < NUM_CLASSES && col_depth < DEPTH_CAP) begin
          qc = (in_quality > QUAL_CAP) ? QUAL_CAP : int'(in_quality);
          div = 64'd1 << (32 - WEIGHT_FRAC_BITS);
          for (int i = 0; i < qc / 10; i++) div = div * 10;
          err = (TENTH_DECADE_TAB[qc % 10] + div / 2) / div;
          if (err == 0) err = 1;
          for (int c = 0; c < NUM_CLASSES; c++) begin
            inc = (c == in_base_class) ? (64'd1 << WEIGHT_FRAC_BITS) - err : err / 5;
            acc = class_sum[c];
            acc = acc + inc;
            class_sum[c] = (acc > 64'hFFFF_FFFF) ? '1 : SUM_W'(acc);
          end
          if (class_obs[in_base_class] != '1) class_obs[in_base_class]++;
          col_depth++;
        end

        if (in_column_end) begin
          peak = '0;
          last_tie = 0;
          for (int c = 0; c < NUM_CLASSES; c++)
            if (class_sum[c] > peak) peak = class_sum[c];
          for (int c = 0; c < NUM_CLASSES; c++)
            if (class_sum[c] == peak) last_tie = c;
          for (int c = 0; c < NUM_CLASSES; c++) begin
            if (class_sum[c] == peak) begin
              mean = 0;
              if (col_depth != 0) mean = class_sum[c] / col_depth;
              if (mean > 65535) mean = 65535;
              v.cls  = CLS_W'(c);
              v.sum  = class_sum[c];
              v.mean = MEAN_W'(mean);
              v.cnt  = class_obs[c];
              v.last = (c == last_tie);
              winners_due.insert(winners_due.size(), v);
            end
          end
          for (int c = 0; c < NUM_CLASSES; c++) begin
            class_sum[c] = '0;
            class_obs[c] = '0;
          end
          col_depth = '0;
        end
      end
    end
    fail_count <= fails;
    pending    <= winners_due.size();
  end

endmodule

>>> tb/pileup_column_consensus_core_tb.sv
// Top of the testbench for pileup_column_consensus_core: clock, reset, stimulus and verdict.
// Sends directed and random pileup columns with random idling on both channels.
// Depends on pcc_pkg, the core and pcc_vote_checker.
module pileup_column_consensus_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcc_pkg::*;

  localparam int MAX_DEPTH        = 65535;
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int OBS_TARGET       = 430;
  localparam int HOLD_CYCLES      = 400;

  localparam logic [CLS_W-1:0] CLS_A    = 3'd0;
  localparam logic [CLS_W-1:0] CLS_C    = 3'd1;
  localparam logic [CLS_W-1:0] CLS_G    = 3'd2;
  localparam logic [CLS_W-1:0] CLS_T    = 3'd3;
  localparam logic [CLS_W-1:0] CLS_N    = 3'd4;
  localparam logic [CLS_W-1:0] CLS_DEL  = 3'd5;
  localparam logic [CLS_W-1:0] CLS_BAD6 = 3'd6;
  localparam logic [CLS_W-1:0] CLS_BAD7 = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CLS_W-1:0]  in_base_class = '0;
  logic [QUAL_W-1:0] in_quality = '0;
  logic              in_column_end = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CLS_W-1:0]  out_winner_class;
  logic [SUM_W-1:0]  out_weight_sum;
  logic [MEAN_W-1:0] out_mean_weight;
  logic [CNT_W-1:0]  out_class_count;
  logic              out_final_winner;
  int                fail_count;
  int                pending;
  bit                hold_rcv = 1'b0;
  int                obs_sent = 0;

  pileup_column_consensus_core #(
    .MAX_DEPTH        (MAX_DEPTH),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_base_class    (in_base_class),
    .in_quality       (in_quality),
    .in_column_end    (in_column_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_winner_class (out_winner_class),
    .out_weight_sum   (out_weight_sum),
    .out_mean_weight  (out_mean_weight),
    .out_class_count  (out_class_count),
    .out_final_winner (out_final_winner)
  );

  pcc_vote_checker #(
    .MAX_DEPTH        (MAX_DEPTH),
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_base_class    (in_base_class),
    .in_quality       (in_quality),
    .in_column_end    (in_column_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_winner_class (out_winner_class),
    .out_weight_sum   (out_weight_sum),
    .out_mean_weight  (out_mean_weight),
    .out_class_count  (out_class_count),
    .out_final_winner (out_final_winner),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_obs(input logic [CLS_W-1:0] cls, input logic [QUAL_W-1:0] q,
                          input logic last);
    in_valid      <= 1'b1;
    in_base_class <= cls;
    in_quality    <= q;
    in_column_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    obs_sent++;
  endtask

  task automatic rest(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : receiver
    bit hold_done;
    int gap;
    hold_done = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_rcv && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int len, r;
    bit calm, tie, paused;
    logic [CLS_W-1:0] lead, other, cls;
    logic [QUAL_W-1:0] tie_q, q;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty column, then a zero-quality call that lets the other five classes tie.
    send_obs(CLS_BAD6, 8'd0, 1'b1);
    send_obs(CLS_A, 8'd0, 1'b1);
    send_obs(CLS_C, 8'd255, 1'b0);
    send_obs(CLS_G, 8'd94, 1'b0);
    send_obs(CLS_T, 8'd93, 1'b0);
    send_obs(CLS_N, 8'd9, 1'b0);
    send_obs(CLS_DEL, 8'd10, 1'b0);
    send_obs(CLS_BAD7, 8'd200, 1'b0);
    send_obs(CLS_A, 8'd1, 1'b1);
    send_obs(CLS_G, 8'd30, 1'b0);
    send_obs(CLS_T, 8'd30, 1'b1);
    send_obs(CLS_N, 8'd40, 1'b1);
    send_obs(CLS_DEL, 8'd20, 1'b0);
    send_obs(CLS_DEL, 8'd170, 1'b0);
    send_obs(CLS_BAD6, 8'd85, 1'b1);
    send_obs(CLS_A, 8'h55, 1'b0);
    send_obs(CLS_C, 8'hAA, 1'b1);
    drain();

    while (obs_sent < OBS_TARGET) begin
      if (!hold_rcv && obs_sent >= 120) begin
        hold_rcv = 1'b1;
        for (int n = 0; n < 12; n++) send_obs(CLS_T, QUAL_W'($urandom_range(0, 93)), 1'b1);
      end
      if (!paused && obs_sent >= OBS_TARGET / 2) begin
        paused = 1'b1;
        drain();
      end
      calm = ($urandom_range(0, 3) == 0);
      tie = ($urandom_range(0, 9) == 0);
      lead = CLS_W'($urandom_range(0, 5));
      other = CLS_W'($urandom_range(0, 5));
      tie_q = QUAL_W'($urandom_range(0, 93));
      if (tie) len = 2 * $urandom_range(1, 3);
      else if ($urandom_range(0, 99) < 85) len = $urandom_range(1, 8);
      else len = $urandom_range(9, 40);
      for (int i = 0; i < len; i++) begin
        if (tie) begin
          cls = i[0] ? other : lead;
          q = tie_q;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 8) cls = CLS_W'($urandom_range(6, 7));
          else if (r < 70) cls = lead;
          else cls = CLS_W'($urandom_range(0, 5));
          r = $urandom_range(0, 99);
          if (r < 50) q = QUAL_W'($urandom_range(20, 45));
          else if (r < 80) q = QUAL_W'($urandom_range(0, 93));
          else q = QUAL_W'($urandom_range(0, 255));
        end
        send_obs(cls, q, i == len - 1);
        rest(calm ? 0 : idle_len());
      end
    end
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("pileup_column_consensus_core_tb: done, clean");
    end else begin
      $display("pileup_column_consensus_core_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("pileup_column_consensus_core_tb: done, errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pcc_pkg.sv
rtl/core/pcc_front.sv
rtl/core/pcc_fifo.sv
rtl/core/pcc_div.sv
rtl/core/pcc_back.sv
rtl/core/pileup_column_consensus_core.sv
tb/pcc_vote_checker.sv
tb/pileup_column_consensus_core_tb.sv
